/* sv/min_max_heap_queue_assert.svh */
// assertion macros for the min-max heap queue
`ifndef MIN_MAX_HEAP_QUEUE_ASSERT_SVH
`define MIN_MAX_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define MMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MMH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MMH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/mmh_pkg.sv */
// shared types and constants for the min-max heap queue
`timescale 1ns / 1ps
package mmh_pkg;
    localparam int DEF_CAPACITY = 1024;
    localparam int KEY_W = 31;
    localparam int ID_W = 16;
    localparam int CNT_OUT_W = 11;
    localparam int ENTRY_W = KEY_W + ID_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0] id;
    } entry_t;
endpackage

/* sv/mmh_ram.sv */
// entry memory of the heap, one write port and one registered read port
`timescale 1ns / 1ps
module mmh_ram
    import mmh_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int AW = $clog2(DEF_CAPACITY)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);
    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/min_max_heap_queue.sv */
// min-max heap queue top level with sequencer and entry memory
//
//  channel | dir | tdata fields (low first)                        | tuser
//  s_axis  | in  | new_key[30:0], new_id[46:31]                     | func
//  m_axis  | out | status[1:0], removed_key[32:2], removed_id[48:33],| none
//          |     | entry_count[59:49]                               |
//
// one request at a time, at most one memory write and one memory read per cycle
// insert: parent compare, then one grandparent compare per grandparent step
// delete: root and last entry read, then per two levels one setup, one descendant scan (six
// reads at most), one decision and one more parent write on a parent swap
// reset clears the fill count, state, scan index and valid flags; entries are undefined until written
// the next request is taken into the input register while one is worked on;
// a stalled m_axis holds the sequencer in its output state
`timescale 1ns / 1ps
`include "min_max_heap_queue_assert.svh"
module min_max_heap_queue
    import mmh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // new_key, new_id
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // status, removed_key, removed_id, entry_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UP_CP = 4'd1;
    localparam logic [3:0] S_UP_RG = 4'd2;
    localparam logic [3:0] S_UP_CG = 4'd3;
    localparam logic [3:0] S_DEL_RL = 4'd4;
    localparam logic [3:0] S_DEL_W0 = 4'd5;
    localparam logic [3:0] S_DN_NEXT = 4'd6;
    localparam logic [3:0] S_DN_SCAN = 4'd7;
    localparam logic [3:0] S_DN_DEC = 4'd8;
    localparam logic [3:0] S_DN_WP = 4'd9;
    localparam logic [3:0] S_DN_WC = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] m_reg, m_next;
    logic [IW-1:0] p_reg, p_next;
    entry_t cur_reg, cur_next;
    entry_t oth_reg, oth_next;
    entry_t best_reg, best_next;
    entry_t ch0_reg, ch0_next;
    entry_t ch1_reg, ch1_next;
    logic max_reg, max_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] st_reg, st_next;
    entry_t rem_reg, rem_next;
    logic in_full_reg, in_full_next;
    logic func_reg, func_next;
    entry_t in_reg, in_next;
    logic ov_reg, ov_next;
    logic [63:0] od_reg, od_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata, rdata;

    mmh_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram
    (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic on_min(input logic [IW-1:0] idx);
        logic [IW:0] v;
        logic lv;
        v = {1'b0, idx} + 1'b1;
        lv = 1'b0;
        for (int b = 0; b <= IW; b++)
        begin
            if (v[b])
            begin
                lv = b[0];
            end
        end
        return !lv;
    endfunction

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] idx);
        return (idx - 1'b1) >> 1;
    endfunction

    assign s_axis_tready = !in_full_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;

    logic [IW-1:0] cnt_i;
    logic [IW-1:0] cnt_m1;
    logic [IW-1:0] lo_idx, first_idx;
    logic [IW-1:0] scan_nxt;
    logic [IW-1:0] par_m;
    logic [IW-1:0] gp_i, gp_j;
    entry_t par_val;
    assign cnt_i = IW'(cnt_reg);
    assign cnt_m1 = cnt_i - 1'b1;
    assign first_idx = {i_reg[IW-2:0], 1'b1};
    assign lo_idx = {i_reg[IW-3:0], 2'b11};
    // candidate order: two children, then up to four grandchildren
    assign scan_nxt = (k_reg == 3'd1) ? lo_idx : j_reg + 1'b1;
    assign par_m = parent_of(m_reg);
    assign par_val = (par_m == first_idx) ? ch0_reg : ch1_reg;
    assign gp_i = parent_of(parent_of(i_reg));
    assign gp_j = parent_of(parent_of(j_reg));

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        m_next = m_reg;
        p_next = p_reg;
        cur_next = cur_reg;
        oth_next = oth_reg;
        best_next = best_reg;
        ch0_next = ch0_reg;
        ch1_next = ch1_reg;
        max_next = max_reg;
        k_next = k_reg;
        st_next = st_reg;
        rem_next = rem_reg;
        in_full_next = in_full_reg;
        func_next = func_reg;
        in_next = in_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        we = 1'b0;
        waddr = i_reg[AW-1:0];
        wdata = cur_reg;
        raddr = j_reg[AW-1:0];

        if (s_axis_tvalid && s_axis_tready)
        begin
            in_full_next = 1'b1;
            func_next = s_axis_tuser;
            in_next.key = s_axis_tdata[30:0];
            in_next.id = s_axis_tdata[46:31];
        end
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_full_reg)
                begin
                    in_full_next = 1'b0;
                    st_next = ST_DONE;
                    rem_next = '0;
                    if (func_reg == FUNC_INSERT)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            i_next = cnt_i;
                            cur_next = in_reg;
                            cnt_next = cnt_reg + 1'b1;
                            if (cnt_reg == '0)
                            begin
                                we = 1'b1;
                                waddr = '0;
                                wdata = in_reg;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                raddr = parent_of(cnt_i)[AW-1:0];
                                j_next = parent_of(cnt_i);
                                state_next = S_UP_CP;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            raddr = '0;
                            state_next = S_DEL_RL;
                        end
                    end
                end
            end
            // new entry is held in cur; slot i is the open hole
            S_UP_CP:
            begin
                max_next = !on_min(i_reg);
                if (on_min(i_reg) ? (cur_reg.key > rdata.key) : (cur_reg.key < rdata.key))
                begin
                    we = 1'b1;
                    wdata = rdata;
                    i_next = j_reg;
                    max_next = on_min(i_reg);
                end
                state_next = S_UP_RG;
            end
            S_UP_RG:
            begin
                if (i_reg <= IW'(2))
                begin
                    we = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    raddr = gp_i[AW-1:0];
                    j_next = gp_i;
                    state_next = S_UP_CG;
                end
            end
            S_UP_CG:
            begin
                we = 1'b1;
                if (max_reg ? (cur_reg.key > rdata.key) : (cur_reg.key < rdata.key))
                begin
                    wdata = rdata;
                    i_next = j_reg;
                    if (j_reg > IW'(2))
                    begin
                        raddr = gp_j[AW-1:0];
                        j_next = gp_j;
                    end
                    else
                    begin
                        state_next = S_UP_RG;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DEL_RL:
            begin
                rem_next = rdata;
                raddr = cnt_m1[AW-1:0];
                cnt_next = cnt_reg - 1'b1;
                state_next = S_DEL_W0;
            end
            S_DEL_W0:
            begin
                cur_next = rdata;
                i_next = '0;
                state_next = (cnt_reg == '0) ? S_OUT : S_DN_NEXT;
            end
            S_DN_NEXT:
            begin
                if (first_idx >= cnt_i)
                begin
                    we = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    raddr = first_idx[AW-1:0];
                    j_next = first_idx;
                    k_next = '0;
                    state_next = S_DN_SCAN;
                end
            end
            // one descendant arrives per cycle while the next one is read
            S_DN_SCAN:
            begin
                if (k_reg == 3'd0 || rdata.key < best_reg.key)
                begin
                    best_next = rdata;
                    m_next = j_reg;
                end
                if (k_reg == 3'd0)
                begin
                    ch0_next = rdata;
                end
                if (k_reg == 3'd1)
                begin
                    ch1_next = rdata;
                end
                if (k_reg != 3'd5 && scan_nxt < cnt_i)
                begin
                    raddr = scan_nxt[AW-1:0];
                    j_next = scan_nxt;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DN_DEC;
                end
            end
            S_DN_DEC:
            begin
                we = 1'b1;
                if (best_reg.key < cur_reg.key)
                begin
                    wdata = best_reg;
                    if (m_reg >= lo_idx)
                    begin
                        i_next = m_reg;
                        state_next = S_DN_NEXT;
                        // moved entry may be larger than the max-level parent of m
                        if (cur_reg.key > par_val.key)
                        begin
                            oth_next = cur_reg;
                            cur_next = par_val;
                            p_next = par_m;
                            state_next = S_DN_WP;
                        end
                    end
                    else
                    begin
                        state_next = S_DN_WC;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DN_WP:
            begin
                we = 1'b1;
                waddr = p_reg[AW-1:0];
                wdata = oth_reg;
                state_next = S_DN_NEXT;
            end
            S_DN_WC:
            begin
                we = 1'b1;
                waddr = m_reg[AW-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {4'd0, CNT_OUT_W'(cnt_reg), rem_reg.id, rem_reg.key, st_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            in_full_reg <= 1'b0;
            ov_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            in_full_reg <= in_full_next;
            ov_reg <= ov_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        m_reg <= m_next;
        p_reg <= p_next;
        cur_reg <= cur_next;
        oth_reg <= oth_next;
        best_reg <= best_next;
        ch0_reg <= ch0_next;
        ch1_reg <= ch1_next;
        max_reg <= max_next;
        st_reg <= st_next;
        rem_reg <= rem_next;
        func_reg <= func_next;
        in_reg <= in_next;
        od_reg <= od_next;
    end

    `MMH_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY))
    `MMH_ASSERT_IMP(a_state_legal, clk, rst_n, 1'b1, state_reg <= S_OUT)
    `MMH_ASSERT_NEXT(a_in_taken, clk, rst_n, s_axis_tvalid && s_axis_tready, in_full_reg)
    `MMH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
